[sv/sparse_set_direct_address_defines.svh]
// assertion macros for the sparse set block
// used by the files that carry concurrent assertions; no other dependencies
`ifndef SPARSE_SET_DIRECT_ADDRESS_DEFINES_SVH
`define SPARSE_SET_DIRECT_ADDRESS_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSDA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sparse set assertion failed");
`define SSDA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sparse set forbidden condition");
`else
`define SSDA_ASSERT(lbl, clk, rstn, prop)
`define SSDA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[sv/ssda_pkg.sv]
// types and constants of the sparse set block
// no dependencies
package ssda_pkg;

  localparam int unsigned UNIVERSE = 128;
  localparam int unsigned KEY_W    = 7;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CMD_W    = 2;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IDX,
    ST_CHK
  } state_e;

  typedef struct packed {
    logic  rd_en;
    key_t  rd_addr;
    logic  wr_en;
    key_t  wr_addr;
    slot_t wr_data;
  } idx_req_t;

  typedef struct packed {
    logic  rd_en;
    slot_t rd_addr_a;
    slot_t rd_addr_b;
    logic  wr_en;
    slot_t wr_addr;
    key_t  wr_data;
  } dense_req_t;

endpackage

[sv/ssda_in_if.sv]
// command channel of the sparse set block
// depends on ssda_pkg
interface ssda_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssda_pkg::CMD_W-1:0] cmd;
  ssda_pkg::key_t             key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

[sv/ssda_out_if.sv]
// result channel of the sparse set block
// depends on ssda_pkg
interface ssda_out_if;
  logic             valid;
  logic             ready;
  logic             hit;
  ssda_pkg::slot_t  slot;
  ssda_pkg::count_t members;

  modport source (output valid, output hit, output slot, output members, input ready);
  modport sink   (input valid, input hit, input slot, input members, output ready);
endinterface

[sv/ssda_idx_ram.sv]
// index store: key to dense slot, one write and one registered read per cycle
// depends on ssda_pkg
module ssda_idx_ram (
  input  logic               clk_i,
  input  ssda_pkg::idx_req_t req_i,
  output ssda_pkg::slot_t    rdata_o
);

  ssda_pkg::slot_t mem_q [ssda_pkg::UNIVERSE];
  ssda_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ssda_dense_ram.sv]
// dense store of member keys, one write and two registered reads per cycle
// depends on ssda_pkg
module ssda_dense_ram (
  input  logic                 clk_i,
  input  ssda_pkg::dense_req_t req_i,
  output ssda_pkg::key_t       rdata_a_o,
  output ssda_pkg::key_t       rdata_b_o
);

  ssda_pkg::key_t mem_q [ssda_pkg::UNIVERSE];
  ssda_pkg::key_t rdata_a_q;
  ssda_pkg::key_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_a_q <= mem_q[req_i.rd_addr_a];
      rdata_b_q <= mem_q[req_i.rd_addr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[sv/ssda_ctrl.sv]
// sequencer of the sparse set: membership check, store updates, result register
// depends on ssda_pkg, ssda_in_if, ssda_out_if and the assertion macro header
`include "sparse_set_direct_address_defines.svh"

module ssda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssda_in_if.sink              in_i,
  ssda_out_if.source           out_o,
  output ssda_pkg::idx_req_t   idx_req_o,
  input  ssda_pkg::slot_t      idx_rdata_i,
  output ssda_pkg::dense_req_t dense_req_o,
  input  ssda_pkg::key_t       dense_a_i,
  input  ssda_pkg::key_t       dense_b_i
);

  ssda_pkg::state_e state_q, state_d;
  ssda_pkg::cmd_e   cmd_q;
  ssda_pkg::key_t   key_q;
  ssda_pkg::slot_t  slot_q, slot_d;
  ssda_pkg::count_t count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_hit_d;
  ssda_pkg::slot_t  out_slot_q, out_slot_d;
  ssda_pkg::count_t out_members_q, out_members_d;

  logic             accept;
  logic             finish;
  logic             hit;
  logic             full;
  ssda_pkg::count_t last_full;
  ssda_pkg::slot_t  last_slot;

  assign accept    = in_i.valid && in_i.ready;
  assign finish    = (state_q == ssda_pkg::ST_CHK) && (!out_valid_q || out_o.ready);
  assign last_full = count_q - ssda_pkg::COUNT_W'(1);
  assign last_slot = last_full[ssda_pkg::SLOT_W-1:0];
  assign full      = (count_q == ssda_pkg::COUNT_W'(ssda_pkg::UNIVERSE));
  assign hit       = ({1'b0, slot_q} < count_q) && (dense_a_i == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssda_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ssda_pkg::ST_IDX;
        end
      end
      ssda_pkg::ST_IDX: begin
        state_d = ssda_pkg::ST_CHK;
      end
      ssda_pkg::ST_CHK: begin
        if (finish) begin
          state_d = ssda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssda_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and store accesses
  always_comb begin
    in_i.ready    = (state_q == ssda_pkg::ST_IDLE);
    idx_req_o     = '0;
    dense_req_o   = '0;
    slot_d        = slot_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_hit_d     = out_hit_q;
    out_slot_d    = out_slot_q;
    out_members_d = out_members_q;

    idx_req_o.rd_en   = accept;
    idx_req_o.rd_addr = in_i.key;

    if (state_q == ssda_pkg::ST_IDX) begin
      slot_d                = idx_rdata_i;
      dense_req_o.rd_en     = 1'b1;
      dense_req_o.rd_addr_a = idx_rdata_i;
      dense_req_o.rd_addr_b = last_slot;
    end

    if (finish) begin
      out_valid_d = 1'b1;
      out_hit_d   = hit;
      out_slot_d  = '0;
      unique case (cmd_q)
        ssda_pkg::CMD_INSERT: begin
          if (hit) begin
            out_slot_d = slot_q;
          end else if (!full) begin
            idx_req_o.wr_en     = 1'b1;
            idx_req_o.wr_addr   = key_q;
            idx_req_o.wr_data   = count_q[ssda_pkg::SLOT_W-1:0];
            dense_req_o.wr_en   = 1'b1;
            dense_req_o.wr_addr = count_q[ssda_pkg::SLOT_W-1:0];
            dense_req_o.wr_data = key_q;
            out_slot_d          = count_q[ssda_pkg::SLOT_W-1:0];
            count_d             = count_q + ssda_pkg::COUNT_W'(1);
          end
        end
        ssda_pkg::CMD_DELETE: begin
          if (hit) begin
            // move the last member into the freed slot
            if (slot_q != last_slot) begin
              dense_req_o.wr_en   = 1'b1;
              dense_req_o.wr_addr = slot_q;
              dense_req_o.wr_data = dense_b_i;
              idx_req_o.wr_en     = 1'b1;
              idx_req_o.wr_addr   = dense_b_i;
              idx_req_o.wr_data   = slot_q;
            end
            count_d = last_full;
          end
        end
        default: begin
          if (hit) begin
            out_slot_d = slot_q;
          end
        end
      endcase
      out_members_d = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssda_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= ssda_pkg::cmd_e'(in_i.cmd);
      key_q <= in_i.key;
    end
    slot_q        <= slot_d;
    out_hit_q     <= out_hit_d;
    out_slot_q    <= out_slot_d;
    out_members_q <= out_members_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.hit     = out_hit_q;
  assign out_o.slot    = out_slot_q;
  assign out_o.members = out_members_q;

  `SSDA_ASSERT_NEVER(a_count_range, clk_i, rst_ni,
    count_q > ssda_pkg::COUNT_W'(ssda_pkg::UNIVERSE))
  `SSDA_ASSERT(a_count_only_at_end, clk_i, rst_ni,
    (state_q != ssda_pkg::ST_CHK) |=> $stable(count_q))
  `SSDA_ASSERT(a_writes_only_at_end, clk_i, rst_ni,
    (idx_req_o.wr_en || dense_req_o.wr_en) |-> finish)
  `SSDA_ASSERT(a_result_from_check, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q) == ssda_pkg::ST_CHK)
  `SSDA_ASSERT(a_accept_starts_lookup, clk_i, rst_ni,
    accept |=> (state_q == ssda_pkg::ST_IDX))

endmodule

[sv/sparse_set_direct_address.sv]
// top level of the direct-address sparse set of 7-bit keys
// depends on ssda_pkg, ssda_in_if, ssda_out_if, ssda_idx_ram, ssda_dense_ram, ssda_ctrl
//
//   port   dir   beat contents            handshake
//   in_i   in    cmd[1:0], key[6:0]       valid / ready
//   out_o  out   hit, slot[6:0], members  valid / ready
//
// each item passes through index store read, dense store read of the
// candidate slot and of the last member, then check and write back.
// the dependent index-then-dense read chain through the two stores sets that order.
// reset clears the member count and the control state; the stores are not cleared.
// a new beat is taken while a finished result still waits; the check step holds
// until the result register is free.
module sparse_set_direct_address (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssda_in_if.sink    in_i,
  ssda_out_if.source out_o
);

  ssda_pkg::idx_req_t   idx_req;
  ssda_pkg::dense_req_t dense_req;
  ssda_pkg::slot_t      idx_rdata;
  ssda_pkg::key_t       dense_a;
  ssda_pkg::key_t       dense_b;

  ssda_idx_ram u_idx_ram (
    .clk_i   (clk_i),
    .req_i   (idx_req),
    .rdata_o (idx_rdata)
  );

  ssda_dense_ram u_dense_ram (
    .clk_i     (clk_i),
    .req_i     (dense_req),
    .rdata_a_o (dense_a),
    .rdata_b_o (dense_b)
  );

  ssda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .idx_req_o   (idx_req),
    .idx_rdata_i (idx_rdata),
    .dense_req_o (dense_req),
    .dense_a_i   (dense_a),
    .dense_b_i   (dense_b)
  );

endmodule

[tb/sparse_set_direct_address_tb.sv]
// self-checking testbench of the direct-address sparse set: directed and random
// insert / search / delete beats with bursty input and a stalling receiver
// depends on ssda_pkg, ssda_in_if, ssda_out_if and sparse_set_direct_address
`timescale 1ns / 100ps

module sparse_set_direct_address_tb;

  localparam logic [ssda_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_BEATS = 1280;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic             hit;
    ssda_pkg::slot_t  slot;
    ssda_pkg::count_t members;
  } reply_t;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_mode_e;

  class sparse_set_tracker;
    ssda_pkg::count_t key_to_slot [ssda_pkg::UNIVERSE];
    ssda_pkg::key_t   slot_to_key [ssda_pkg::UNIVERSE];
    int unsigned      member_total;
    reply_t           pending_replies [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      hits;
    int unsigned      full_events;
    int unsigned      empty_events;
    int unsigned      cmd_seen [4];

    function new();
      foreach (key_to_slot[k]) key_to_slot[k] = '0;
      foreach (slot_to_key[s]) slot_to_key[s] = '0;
      member_total = 0;
    endfunction

    function bit holds(ssda_pkg::key_t key);
      int unsigned s;
      s = key_to_slot[key];
      return (s < member_total) && (slot_to_key[s] == key);
    endfunction

    function reply_t apply_command(logic [ssda_pkg::CMD_W-1:0] cmd, ssda_pkg::key_t key);
      reply_t         r;
      int unsigned    s;
      int unsigned    last;
      ssda_pkg::key_t moved;
      bit             found;
      found   = holds(key);
      s       = key_to_slot[key];
      r.hit   = found;
      r.slot  = '0;
      case (cmd)
        ssda_pkg::CMD_INSERT: begin
          if (found) begin
            r.slot = ssda_pkg::slot_t'(s);
          end else if (member_total < ssda_pkg::UNIVERSE) begin
            key_to_slot[key]          = ssda_pkg::count_t'(member_total);
            slot_to_key[member_total] = key;
            r.slot                    = ssda_pkg::slot_t'(member_total);
            member_total++;
          end
        end
        ssda_pkg::CMD_DELETE: begin
          if (found) begin
            last = member_total - 1;
            if (s != last) begin
              moved              = slot_to_key[last];
              slot_to_key[s]     = moved;
              key_to_slot[moved] = ssda_pkg::count_t'(s);
            end
            member_total = last;
          end
        end
        default: begin
          if (found) r.slot = ssda_pkg::slot_t'(s);
        end
      endcase
      r.members = ssda_pkg::count_t'(member_total);
      return r;
    endfunction

    function void record_command(logic [ssda_pkg::CMD_W-1:0] cmd, ssda_pkg::key_t key);
      int unsigned total_was;
      total_was = member_total;
      pending_replies.insert(pending_replies.size(), apply_command(cmd, key));
      cmd_seen[cmd]++;
      if (member_total == ssda_pkg::UNIVERSE && total_was != ssda_pkg::UNIVERSE) full_events++;
      if (member_total == 0 && total_was != 0) empty_events++;
    endfunction

    function void check_result(logic hit, ssda_pkg::slot_t slot, ssda_pkg::count_t members);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: hit %b slot %0d members %0d", hit, slot, members);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (want.hit) hits++;
      if (hit !== want.hit || slot !== want.slot || members !== want.members) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d: expected hit %b slot %0d members %0d,",
                   checked, want.hit, want.slot, want.members);
          $display("  got hit %b slot %0d members %0d", hit, slot, members);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ssda_in_if  in_if ();
  ssda_out_if out_if ();

  sparse_set_direct_address i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sparse_set_tracker tracker = new();

  int unsigned    beats_sent;
  int unsigned    burst_left;
  bit             long_hold_done;
  bit             key_written [ssda_pkg::UNIVERSE];
  ssda_pkg::key_t written_keys [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result check first, so a result never pairs with a beat taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        tracker.check_result(out_if.hit, out_if.slot, out_if.members);
      if (in_if.valid && in_if.ready)
        tracker.record_command(in_if.cmd, in_if.key);
    end
  end

  task automatic offer_beat(logic [ssda_pkg::CMD_W-1:0] cmd, ssda_pkg::key_t key);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.key   <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    beats_sent++;
    if (cmd == ssda_pkg::CMD_INSERT && !key_written[key]) begin
      key_written[key] = 1'b1;
      written_keys.insert(written_keys.size(), key);
    end
  endtask

  task automatic drain_replies();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // search and delete only touch keys that were inserted at some point
  task automatic random_beat(mix_mode_e mode);
    int unsigned                 roll;
    int unsigned                 w_ins;
    int unsigned                 w_srch;
    int unsigned                 w_del;
    int unsigned                 total;
    logic [ssda_pkg::CMD_W-1:0] cmd;
    ssda_pkg::key_t              key;
    case (mode)
      MODE_FILL: begin
        w_ins = 75; w_srch = 12; w_del = 8;
      end
      MODE_MIX: begin
        w_ins = 35; w_srch = 30; w_del = 30;
      end
      default: begin
        w_ins = 10; w_srch = 15; w_del = 70;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < w_ins) cmd = ssda_pkg::CMD_INSERT;
    else if (roll < w_ins + w_srch) cmd = ssda_pkg::CMD_SEARCH;
    else if (roll < w_ins + w_srch + w_del) cmd = ssda_pkg::CMD_DELETE;
    else cmd = CMD_UNUSED;
    total = tracker.member_total;
    if (written_keys.size() == 0) cmd = ssda_pkg::CMD_INSERT;
    if (cmd == ssda_pkg::CMD_INSERT) begin
      if (total > 0 && $urandom_range(99) < 20) begin
        key = tracker.slot_to_key[$urandom_range(total - 1)];
      end else begin
        key = ssda_pkg::key_t'($urandom_range(ssda_pkg::UNIVERSE - 1));
        if (total < ssda_pkg::UNIVERSE)
          while (tracker.holds(key))
            key = ssda_pkg::key_t'($urandom_range(ssda_pkg::UNIVERSE - 1));
      end
    end else if (total > 0 && $urandom_range(99) < 80) begin
      key = tracker.slot_to_key[$urandom_range(total - 1)];
    end else begin
      key = written_keys[$urandom_range(written_keys.size() - 1)];
    end
    offer_beat(cmd, key);
  endtask

  initial begin
    int unsigned stretch_left;
    int unsigned ready_pct;
    stretch_left = 0;
    ready_pct    = 100;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!long_hold_done && beats_sent >= HOLD_AT) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(64, 8);
          case ($urandom_range(3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 50;
            default: ready_pct = 20;
          endcase
        end
        stretch_left--;
        out_if.ready <= ($urandom_range(99) < ready_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin
    mix_mode_e   mode;
    int unsigned mix_left;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd   <= ssda_pkg::CMD_INSERT;
    in_if.key   <= '0;
    burst_left  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, duplicates, move on delete, last-member delete, stale index, empty set
    offer_beat(ssda_pkg::CMD_INSERT, 7'd0);
    offer_beat(ssda_pkg::CMD_INSERT, 7'd127);
    offer_beat(ssda_pkg::CMD_INSERT, 7'd0);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd127);
    offer_beat(CMD_UNUSED, 7'd0);
    offer_beat(ssda_pkg::CMD_INSERT, 7'd85);
    offer_beat(ssda_pkg::CMD_INSERT, 7'd42);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd0);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd42);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd0);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd0);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd85);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd85);
    offer_beat(CMD_UNUSED, 7'd85);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd127);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd42);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd127);
    offer_beat(ssda_pkg::CMD_DELETE, 7'd127);
    offer_beat(ssda_pkg::CMD_INSERT, 7'd127);
    offer_beat(ssda_pkg::CMD_SEARCH, 7'd127);

    mode     = MODE_FILL;
    mix_left = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 400 || i == 1000) drain_replies();
      case (mode)
        MODE_FILL: begin
          if (tracker.member_total == ssda_pkg::UNIVERSE) begin
            mode     = MODE_MIX;
            mix_left = 150;
          end
        end
        MODE_MIX: begin
          if (mix_left == 0) mode = MODE_DRAIN;
          else mix_left--;
        end
        default: begin
          if (tracker.member_total == 0) mode = MODE_FILL;
        end
      endcase
      random_beat(mode);
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d beats: %0d insert, %0d search, %0d delete, %0d unused code, %0d hits",
             beats_sent, tracker.cmd_seen[ssda_pkg::CMD_INSERT],
             tracker.cmd_seen[ssda_pkg::CMD_SEARCH], tracker.cmd_seen[ssda_pkg::CMD_DELETE],
             tracker.cmd_seen[CMD_UNUSED], tracker.hits);
    $display("set reached capacity %0d times and went empty %0d times; %0d mismatches",
             tracker.full_events, tracker.empty_events, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
